FILE: hw/rtl/brft_pkg.sv
// ----------------------------------------------------------------------------
// brft_pkg
// shared types, constants and frame build function for the blind remote
// frame transmitter
// ----------------------------------------------------------------------------
package brft_pkg;

	localparam int FRAME_W = 56;
	localparam int DUR_W   = 17;
	localparam int SYM_W   = 12;
	localparam int KEY_W   = 8;
	localparam int CNT_W   = 6;
	localparam int IDX_W   = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_KEY_BYTE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SYMBOL_US = 2'd1;

	localparam logic [KEY_W-1:0] KEY_BYTE_RST  = 8'hA7;
	localparam logic [SYM_W-1:0] SYMBOL_US_RST = 12'd640;

	// fixed phase durations in microseconds
	localparam logic [DUR_W-1:0] WAKE_HIGH_US = 17'd9415;
	localparam logic [DUR_W-1:0] WAKE_LOW_US  = 17'd89565;
	localparam logic [DUR_W-1:0] SOFT_HIGH_US = 17'd4550;
	localparam logic [DUR_W-1:0] TAIL_LOW_US  = 17'd30415;

	// result slot positions within a frame
	localparam logic [CNT_W-1:0] CNT_WAKE      = 6'd0;
	localparam logic [CNT_W-1:0] CNT_HW_LAST   = 6'd2;
	localparam logic [CNT_W-1:0] CNT_SOFT      = 6'd3;
	localparam logic [CNT_W-1:0] CNT_DATA_LAST = 6'd59;
	localparam logic [CNT_W-1:0] CNT_LAST      = 6'd60;

	typedef logic [FRAME_W-1:0] frame_t;

	// front to queue push request
	typedef struct packed {
		logic   valid;
		frame_t frame;
	} push_req_t;

	// queue to back status
	typedef struct packed {
		logic   valid;
		frame_t frame;
	} q_head_t;

	function automatic frame_t build_frame(input logic [KEY_W-1:0] key,
			input logic [3:0] button, input logic [15:0] code,
			input logic [23:0] addr);
		logic [7:0] fr [7];
		logic [3:0] sum;
		frame_t     res;
		fr[0] = key;
		fr[1] = {button, 4'h0};
		fr[2] = code[15:8];
		fr[3] = code[7:0];
		fr[4] = addr[23:16];
		fr[5] = addr[15:8];
		fr[6] = addr[7:0];
		sum = 4'h0;
		for (int i = 0; i < 7; i++) begin
			sum = sum ^ fr[i][7:4] ^ fr[i][3:0];
		end
		fr[1] = {button, sum};
		// chain each byte with the previous obfuscated one
		for (int i = 1; i < 7; i++) begin
			fr[i] = fr[i] ^ fr[i-1];
		end
		res = {fr[0], fr[1], fr[2], fr[3], fr[4], fr[5], fr[6]};
		return res;
	endfunction

endpackage

FILE: hw/rtl/blind_remote_frame_transmitter.sv
// ----------------------------------------------------------------------------
// blind_remote_frame_transmitter
// builds a rolling-code command frame and emits its 61 line pulse pairs
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        request    in_valid / in_ready   button, rolling_code, remote_address
//  out       result     out_valid / out_ready first/second level and us, last
//  cfg       write      cfg_we                cfg_index, cfg_data
//
//  each request yields 61 results, one per cycle unless out_ready stalls the
//  back sequencer; queued frames follow one another with no gap
//  the front builds the frame in the accept cycle and queues it (two entries),
//  so requests are taken while an earlier frame is still being sent
//  out_ready low holds the output register and stalls only the sequencer
//  reset clears the queue, the sequencer and restores key 0xA7, symbol 640 us
// ----------------------------------------------------------------------------
module blind_remote_frame_transmitter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [brft_pkg::IDX_W-1:0] cfg_index,
	input  logic [brft_pkg::SYM_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [3:0]                 button,
	input  logic [15:0]                rolling_code,
	input  logic [23:0]                remote_address,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       first_level,
	output logic [brft_pkg::DUR_W-1:0] first_us,
	output logic                       second_level,
	output logic [brft_pkg::DUR_W-1:0] second_us,
	output logic                       last
);
	import brft_pkg::*;

	logic [KEY_W-1:0] key_byte_q;
	logic [SYM_W-1:0] symbol_us_q;
	push_req_t        push;
	q_head_t          head;
	logic             q_full;
	logic             pop;

	// configuration registers, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_byte_q  <= KEY_BYTE_RST;
			symbol_us_q <= SYMBOL_US_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_BYTE) begin
				key_byte_q <= cfg_data[KEY_W-1:0];
			end else if (cfg_index == REG_SYMBOL_US) begin
				symbol_us_q <= cfg_data;
			end
		end
	end

	// front: checksum, obfuscation chain, push into the queue
	brft_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button         (button),
		.rolling_code   (rolling_code),
		.remote_address (remote_address),
		.key_byte       (key_byte_q),
		.q_full         (q_full),
		.push           (push)
	);

	// queue decouples request acceptance from pulse generation
	brft_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// back: wake-up, syncs, manchester data, trailing silence
	brft_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.symbol_us    (symbol_us_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.first_level  (first_level),
		.first_us     (first_us),
		.second_level (second_level),
		.second_us    (second_us),
		.last         (last)
	);

endmodule

FILE: hw/rtl/brft_front.sv
// ----------------------------------------------------------------------------
// brft_front
// takes command requests and builds the obfuscated 56-bit frame
// ----------------------------------------------------------------------------
module brft_front (
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                button,
	input  logic [15:0]               rolling_code,
	input  logic [23:0]               remote_address,
	input  logic [brft_pkg::KEY_W-1:0] key_byte,
	input  logic                      q_full,
	output brft_pkg::push_req_t       push
);
	import brft_pkg::*;

	assign in_ready   = !q_full;
	assign push.valid = in_valid && !q_full;
	assign push.frame = build_frame(key_byte, button, rolling_code, remote_address);

endmodule

FILE: hw/rtl/brft_fifo.sv
// ----------------------------------------------------------------------------
// brft_fifo
// two-entry frame queue between front and back
// ----------------------------------------------------------------------------
module brft_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  brft_pkg::push_req_t push,
	output logic                full,
	input  logic                pop,
	output brft_pkg::q_head_t   head
);
	import brft_pkg::*;

	frame_t     entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.frame = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push.valid) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/brft_back.sv
// ----------------------------------------------------------------------------
// brft_back
// pulse-pair sequencer: walks the 61 result slots of one frame
// ----------------------------------------------------------------------------
module brft_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  brft_pkg::q_head_t          head,
	output logic                       pop,
	input  logic [brft_pkg::SYM_W-1:0] symbol_us,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       first_level,
	output logic [brft_pkg::DUR_W-1:0] first_us,
	output logic                       second_level,
	output logic [brft_pkg::DUR_W-1:0] second_us,
	output logic                       last
);
	import brft_pkg::*;

	logic             active_q;
	logic [CNT_W-1:0] cnt_q;
	frame_t           frame_q;
	logic             out_valid_q;
	logic             advance;
	logic             is_data;
	logic [DUR_W-1:0] sym;
	logic [DUR_W-1:0] sym4;
	logic             n_l1, n_l2, n_last;
	logic [DUR_W-1:0] n_d1, n_d2;

	assign sym     = {{(DUR_W-SYM_W){1'b0}}, symbol_us};
	assign sym4    = {{(DUR_W-SYM_W-2){1'b0}}, symbol_us, 2'b00};
	assign advance = active_q && (!out_valid_q || out_ready);
	assign pop     = head.valid && (!active_q || (advance && cnt_q == CNT_LAST));
	assign is_data = (cnt_q > CNT_SOFT) && (cnt_q <= CNT_DATA_LAST);

	always_comb begin
		n_l1   = 1'b1;
		n_d1   = sym;
		n_l2   = 1'b0;
		n_d2   = sym;
		n_last = 1'b0;
		priority if (cnt_q == CNT_WAKE) begin
			n_d1 = WAKE_HIGH_US;
			n_d2 = WAKE_LOW_US;
		end else if (cnt_q <= CNT_HW_LAST) begin
			n_d1 = sym4;
			n_d2 = sym4;
		end else if (cnt_q == CNT_SOFT) begin
			n_d1 = SOFT_HIGH_US;
		end else if (is_data) begin
			// manchester: one is low then high
			n_l1 = !frame_q[FRAME_W-1];
			n_l2 = frame_q[FRAME_W-1];
		end else begin
			n_l1   = 1'b0;
			n_d1   = TAIL_LOW_US;
			n_d2   = '0;
			n_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_WAKE;
			end else if (advance) begin
				if (cnt_q == CNT_LAST) begin
					active_q <= 1'b0;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= head.frame;
		end else if (advance && is_data) begin
			frame_q <= {frame_q[FRAME_W-2:0], 1'b0};
		end
		if (advance) begin
			first_level  <= n_l1;
			first_us     <= n_d1;
			second_level <= n_l2;
			second_us    <= n_d2;
			last         <= n_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: test/blind_remote_frame_transmitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blind_remote_frame_transmitter_tb
// self-checking bench for the rolling-code frame transmitter: a table of
// directed requests (typed frames for the reset state and the extremes), then
// phases of random requests under random register settings, with both
// handshakes idling at random; every pulse pair is checked against a local
// frame encoder and pulse sequencer
// ----------------------------------------------------------------------------
module blind_remote_frame_transmitter_tb;

	import brft_pkg::*;

	// unused register slots, writes there must have no effect
	localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int PULSES_PER_FRAME = 61;
	localparam int NUM_DIR          = 20;
	localparam int NUM_RANDOM       = 200;
	// cycle ceiling for the run-length guard
	localparam int CYCLE_LIMIT      = 1000000;
	// quiet period after the last pulse pair
	localparam int TAIL_CYCLES      = 70;

	// register action ahead of a table row
	typedef enum logic [1:0] {
		CFG_KEEP,
		CFG_WRITE,
		CFG_JUNK
	} cfg_act_e;

	typedef struct packed {
		cfg_act_e           act;
		logic [SYM_W-1:0]   key_w;
		logic [SYM_W-1:0]   sym_w;
		logic [3:0]         btn;
		logic [15:0]        code;
		logic [23:0]        addr;
		logic               typed;
		logic [FRAME_W-1:0] frame;
	} dir_row_t;

	typedef struct packed {
		logic             first_level;
		logic [DUR_W-1:0] first_us;
		logic             second_level;
		logic [DUR_W-1:0] second_us;
		logic             last;
	} pulse_pair_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [SYM_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [3:0]           button;
	logic [15:0]          rolling_code;
	logic [23:0]          remote_address;
	logic                 out_valid;
	logic                 out_ready;
	logic                 first_level;
	logic [DUR_W-1:0]     first_us;
	logic                 second_level;
	logic [DUR_W-1:0]     second_us;
	logic                 last;

	// shadow copy of the two registers
	logic [KEY_W-1:0]     key_reg = KEY_BYTE_RST;
	logic [SYM_W-1:0]     sym_reg = SYMBOL_US_RST;

	pulse_pair_t          pending_pulses [$];
	int                   mismatch_cnt   = 0;
	int                   requests_sent  = 0;
	int                   pulses_checked = 0;
	int                   settings_used  = 0;
	int                   cycle_cnt      = 0;
	int                   snd_gap_max    = 16;
	int                   rcv_stall_max  = 2;

	// directed requests: reset state, unused register slots, key and symbol
	// extremes, zero symbol time, every button code, walking code patterns
	dir_row_t dir_tab [NUM_DIR] = '{
		'{CFG_KEEP,  12'h000, 12'd0,    4'h0, 16'h0000, 24'h000000, 1'b1, 56'hA7AAAAAAAAAAAA},
		'{CFG_JUNK,  12'h000, 12'd0,    4'hF, 16'hFFFF, 24'hFFFFFF, 1'b1, 56'hA755AA55AA55AA},
		'{CFG_WRITE, 12'h000, 12'd1,    4'h0, 16'h0000, 24'h000000, 1'b1, 56'h00000000000000},
		'{CFG_WRITE, 12'hFFF, 12'd4095, 4'h0, 16'h0000, 24'h000000, 1'b1, 56'hFFFFFFFFFFFFFF},
		'{CFG_KEEP,  12'h000, 12'd0,    4'hF, 16'hFFFF, 24'hFFFFFF, 1'b1, 56'hFF00FF00FF00FF},
		'{CFG_WRITE, 12'h35A, 12'd0,    4'h5, 16'h1234, 24'hABCDEF, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'hA, 16'h8000, 24'h800000, 1'b0, 56'h0},
		'{CFG_WRITE, 12'h0A7, 12'd640,  4'h1, 16'h0001, 24'h000001, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h2, 16'h00FF, 24'h0000FF, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h3, 16'hFF00, 24'hFF0000, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h4, 16'h5555, 24'h555555, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h6, 16'hAAAA, 24'hAAAAAA, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h7, 16'h0F0F, 24'h0F0F0F, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h8, 16'hF0F0, 24'hF0F0F0, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h9, 16'h0100, 24'h010000, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'hB, 16'h7FFF, 24'h7FFFFF, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'hC, 16'hFFFE, 24'hFFFFFE, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'hD, 16'h1357, 24'h2468AC, 1'b0, 56'h0},
		'{CFG_WRITE, 12'h0C3, 12'd2,    4'hE, 16'h0000, 24'hFFFFFF, 1'b0, 56'h0},
		'{CFG_KEEP,  12'h000, 12'd0,    4'h0, 16'hFFFF, 24'h000000, 1'b0, 56'h0}
	};

	blind_remote_frame_transmitter u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button         (button),
		.rolling_code   (rolling_code),
		.remote_address (remote_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.first_level    (first_level),
		.first_us       (first_us),
		.second_level   (second_level),
		.second_us      (second_us),
		.last           (last)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run-length guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pulse pairs still awaited",
				cycle_cnt, pending_pulses.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// plain frame: key, button and zero nibble, code, address; the checksum
	// nibble is the xor of all fourteen nibbles, then each byte is chained
	// with the already scrambled byte ahead of it
	function automatic logic [FRAME_W-1:0] encode_frame(input logic [KEY_W-1:0] key,
			input logic [3:0] btn, input logic [15:0] code, input logic [23:0] addr);
		logic [FRAME_W-1:0] plain;
		logic [FRAME_W-1:0] chained;
		logic [3:0]         csum;
		plain = {key, btn, 4'h0, code, addr};
		csum  = 4'h0;
		for (int n = 0; n < 14; n++)
			csum = csum ^ plain[n*4 +: 4];
		plain[43:40]    = csum;
		chained[55:48]  = plain[55:48];
		for (int b = 1; b < 7; b++)
			chained[55-8*b -: 8] = plain[55-8*b -: 8] ^ chained[63-8*b -: 8];
		return chained;
	endfunction

	task automatic push_pair(input logic l1, input logic [DUR_W-1:0] d1,
			input logic l2, input logic [DUR_W-1:0] d2, input logic fin);
		pulse_pair_t p;
		p.first_level  = l1;
		p.first_us     = d1;
		p.second_level = l2;
		p.second_us    = d2;
		p.last         = fin;
		pending_pulses.push_back(p);
	endtask

	// wake-up, two hardware syncs, software sync, 56 manchester bits msb
	// first, trailing silence
	task automatic queue_pulses(input logic [FRAME_W-1:0] frame);
		logic [DUR_W-1:0] sym;
		logic [DUR_W-1:0] hw;
		sym = DUR_W'(sym_reg);
		hw  = sym << 2;
		push_pair(1'b1, WAKE_HIGH_US, 1'b0, WAKE_LOW_US, 1'b0);
		push_pair(1'b1, hw, 1'b0, hw, 1'b0);
		push_pair(1'b1, hw, 1'b0, hw, 1'b0);
		push_pair(1'b1, SOFT_HIGH_US, 1'b0, sym, 1'b0);
		for (int i = FRAME_W - 1; i >= 0; i--) begin
			if (frame[i])
				push_pair(1'b0, sym, 1'b1, sym, 1'b0);
			else
				push_pair(1'b1, sym, 1'b0, sym, 1'b0);
		end
		push_pair(1'b0, TAIL_LOW_US, 1'b0, '0, 1'b1);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// result side: compare every accepted pulse pair with the oldest one due
	always @(posedge clk) begin : pulse_check
		pulse_pair_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pulses.size() == 0) begin
				$error("pulse pair with none outstanding: first_us %0d second_us %0d",
					first_us, second_us);
				mismatch_cnt++;
			end else begin
				want = pending_pulses.pop_front();
				check_field("first_level", 32'(want.first_level), 32'(first_level));
				check_field("first_us", 32'(want.first_us), 32'(first_us));
				check_field("second_level", 32'(want.second_level), 32'(second_level));
				check_field("second_us", 32'(want.second_us), 32'(second_us));
				check_field("last", 32'(want.last), 32'(last));
				pulses_checked++;
			end
		end
	end

	// receiver: stalls a random number of cycles ahead of each pulse pair
	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, rcv_stall_max);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// sender pause: drop valid and let every outstanding pulse pair drain
	task automatic wait_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_pulses.size() != 0)
			@(posedge clk);
	endtask

	// register writes back to back: optionally key and symbol time, then optionally
	// the two unused slots, which must leave both registers alone
	task automatic apply_config(input logic [SYM_W-1:0] key_w,
			input logic [SYM_W-1:0] sym_w, input bit real_w, input bit junk_w);
		cfg_we <= 1'b1;
		if (real_w) begin
			cfg_index <= REG_KEY_BYTE;
			cfg_data  <= key_w;
			@(posedge clk);
			key_reg = key_w[KEY_W-1:0];
			cfg_index <= REG_SYMBOL_US;
			cfg_data  <= sym_w;
			@(posedge clk);
			sym_reg = sym_w;
		end
		if (junk_w) begin
			cfg_index <= REG_SPARE_2;
			cfg_data  <= SYM_W'($urandom);
			@(posedge clk);
			cfg_index <= REG_SPARE_3;
			cfg_data  <= SYM_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// one request: random gap, hold valid and payload until taken, then
	// queue its 61 pulse pairs from the typed frame or the local encoder
	task automatic send_request(input logic [3:0] btn, input logic [15:0] code,
			input logic [23:0] addr, input bit typed, input logic [FRAME_W-1:0] typed_frame);
		int                 gap;
		logic [FRAME_W-1:0] frame;
		gap = $urandom_range(0, snd_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		button         <= btn;
		rolling_code   <= code;
		remote_address <= addr;
		do @(posedge clk); while (!in_ready);
		frame = typed ? typed_frame : encode_frame(key_reg, btn, code, addr);
		queue_pulses(frame);
		requests_sent++;
	endtask

	function automatic int pick_idle_max();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 4;
			default: return 16;
		endcase
	endfunction

	initial begin : stimulus
		int               rand_sent;
		int               phase_len;
		logic [SYM_W-1:0] key_w;
		logic [SYM_W-1:0] sym_w;
		logic [3:0]       btn;
		logic [15:0]      code;
		logic [23:0]      addr;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_KEY_BYTE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		button         = '0;
		rolling_code   = '0;
		remote_address = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, registers only touched once the block has drained
		for (int r = 0; r < NUM_DIR; r++) begin
			if (dir_tab[r].act != CFG_KEEP) begin
				wait_idle();
				apply_config(dir_tab[r].key_w, dir_tab[r].sym_w,
					dir_tab[r].act == CFG_WRITE, dir_tab[r].act == CFG_JUNK);
			end
			send_request(dir_tab[r].btn, dir_tab[r].code, dir_tab[r].addr,
				dir_tab[r].typed, dir_tab[r].frame);
		end

		// random phases, each with its own register setting and idle pattern
		rand_sent = 0;
		while (rand_sent < NUM_RANDOM) begin
			wait_idle();
			key_w = SYM_W'($urandom);
			case ($urandom_range(0, 7))
				0:       sym_w = '0;
				1:       sym_w = 12'd1;
				2:       sym_w = 12'd4095;
				default: sym_w = SYM_W'($urandom_range(1, 4095));
			endcase
			apply_config(key_w, sym_w, 1'b1, 1'($urandom_range(0, 1)));
			snd_gap_max   = pick_idle_max();
			rcv_stall_max = pick_idle_max();
			phase_len     = $urandom_range(10, 40);
			for (int k = 0; k < phase_len && rand_sent < NUM_RANDOM; k++) begin
				btn  = 4'($urandom);
				code = 16'($urandom);
				addr = 24'($urandom);
				// now and then pin the wide fields to their ends
				if ($urandom_range(0, 7) == 0)
					code = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				if ($urandom_range(0, 7) == 0)
					addr = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
				// sender holds off until the block has gone quiet
				if ($urandom_range(0, 15) == 0)
					wait_idle();
				send_request(btn, code, addr, 1'b0, '0);
				rand_sent++;
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_pulses.size() != 0) begin
			$error("%0d pulse pairs never arrived", pending_pulses.size());
			mismatch_cnt++;
		end

		$display("covered %0d requests over %0d register settings, %0d pulse pairs compared",
			requests_sent, settings_used, pulses_checked);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
